>>> hw/rtl/rpcm_pkg.sv
// ----------------------------------------------------------------------------
// rpcm_pkg: shared types and constants for the relay power channel manager
// Event codes, channel state codes, relay bit positions, queue entry type.
// ----------------------------------------------------------------------------
package rpcm_pkg;

    localparam int unsigned CHANNELS      = 4;
    localparam int unsigned SETTLE_MS_DEF = 50;
    localparam int unsigned QUEUE_DEPTH   = 2;

    typedef enum logic [2:0] {
        EV_TICK  = 3'd0,
        EV_VCU   = 3'd1,
        EV_ACCUM = 3'd2,
        EV_SPEED = 3'd3,
        EV_ALT   = 3'd4,
        EV_APPLY = 3'd5
    } ev_t;

    typedef enum logic [2:0] {
        ST_OFF   = 3'd0,
        ST_TON   = 3'd1,
        ST_ON    = 3'd2,
        ST_TOFF  = 3'd3,
        ST_FAULT = 3'd4
    } ch_state_t;

    typedef enum logic [2:0] {
        CFG_OVR_WINDOW = 3'd0,
        CFG_LOCKOUT    = 3'd1,
        CFG_ALT_PERIOD = 3'd2,
        CFG_RAD_ON     = 3'd3,
        CFG_RAD_OFF    = 3'd4,
        CFG_ACC_ON     = 3'd5,
        CFG_ACC_OFF    = 3'd6,
        CFG_MAX_RPM    = 3'd7
    } cfg_idx_t;

    localparam int unsigned BIT_PUMP = 0;
    localparam int unsigned BIT_DRS  = 1;
    localparam int unsigned BIT_FANS = 2;
    localparam int unsigned BIT_RAD  = 3;

    // classified event, as passed from front to back
    typedef struct packed {
        logic              valid_type;   // set when type is 0..5
        logic [2:0]        ev;
        logic [31:0]       now_ms;
        logic [3:0]        mask;         // already gated by vcu_enable
        logic              alt_req;
        logic signed [15:0] accum_temp;
        logic signed [15:0] motor_speed;
        logic              coolant_valid;
        logic signed [15:0] coolant_temp;
        logic              pump_demand;
        logic [3:0]        sense;
    } rpcm_item_t;

endpackage

>>> hw/rtl/relay_power_channel_manager.sv
// ----------------------------------------------------------------------------
// relay_power_channel_manager: four-relay drive controller
// Front input register, two-entry queue, back execution unit with result reg.
// ----------------------------------------------------------------------------
// Path: input beat -> front reg -> queue -> result reg, all stalled by m_ready.
// Throughput: one event per cycle while m_ready allows; the back unit updates all state.
// Reset: synchronous active-low aresetn resets control and state regs, relays off.
// Configuration writes take effect the cycle after the beat; cfg_ready is high.
module relay_power_channel_manager
    import rpcm_pkg::*;
#(
    parameter int unsigned SETTLE_MS = SETTLE_MS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_req_type,
    input  logic [31:0]        s_now_ms,
    input  logic               s_vcu_enable,
    input  logic [3:0]         s_cmd_mask,
    input  logic               s_alternate_request,
    input  logic signed [15:0] s_accum_temp_decic,
    input  logic signed [15:0] s_motor_speed,
    input  logic               s_coolant_valid,
    input  logic signed [15:0] s_coolant_temp_decic,
    input  logic               s_pump_demand,
    input  logic [3:0]         s_relay_sense,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_drive_mask,
    output logic [3:0]         m_sensed_mask,
    output logic [3:0]         m_commanded_bits,
    output logic [11:0]        m_relay_states,
    output logic               m_fault_raised,
    output logic               m_alternate_active,
    output logic               m_alternate_phase,
    output logic [31:0]        m_ms_since_command
);

    // front -> queue
    logic       f_valid, f_ready;
    rpcm_item_t f_item;
    // queue -> back
    logic       q_valid, q_ready;
    rpcm_item_t q_item;

    rpcm_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_req_type, .s_now_ms, .s_vcu_enable,
        .s_cmd_mask, .s_alternate_request, .s_accum_temp_decic, .s_motor_speed,
        .s_coolant_valid, .s_coolant_temp_decic, .s_pump_demand, .s_relay_sense,
        .f_valid, .f_ready, .f_item
    );

    rpcm_queue u_queue (
        .aclk, .aresetn,
        .w_valid(f_valid), .w_ready(f_ready), .w_item(f_item),
        .r_valid(q_valid), .r_ready(q_ready), .r_item(q_item)
    );

    rpcm_back #(.SETTLE_MS(SETTLE_MS)) u_back (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .q_valid, .q_ready, .q_item,
        .m_valid, .m_ready, .m_drive_mask, .m_sensed_mask, .m_commanded_bits,
        .m_relay_states, .m_fault_raised, .m_alternate_active, .m_alternate_phase,
        .m_ms_since_command
    );

endmodule

>>> hw/rtl/rpcm_front.sv
// ----------------------------------------------------------------------------
// rpcm_front: input stage
// Registers an incoming beat, decodes its type and gates the command mask and alt request.
// ----------------------------------------------------------------------------
module rpcm_front
    import rpcm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_req_type,
    input  logic [31:0]        s_now_ms,
    input  logic               s_vcu_enable,
    input  logic [3:0]         s_cmd_mask,
    input  logic               s_alternate_request,
    input  logic signed [15:0] s_accum_temp_decic,
    input  logic signed [15:0] s_motor_speed,
    input  logic               s_coolant_valid,
    input  logic signed [15:0] s_coolant_temp_decic,
    input  logic               s_pump_demand,
    input  logic [3:0]         s_relay_sense,
    output logic               f_valid,
    input  logic               f_ready,
    output rpcm_item_t         f_item
);

    logic       hold_reg;
    rpcm_item_t item_reg;
    rpcm_item_t item_next;
    logic       gate;

    assign s_ready = !hold_reg || f_ready;
    assign f_valid = hold_reg;
    assign f_item  = item_reg;

    always_comb begin
        gate = (s_req_type == EV_VCU) && !s_vcu_enable;
        item_next.valid_type    = (s_req_type <= EV_APPLY);
        item_next.ev            = s_req_type;
        item_next.now_ms        = s_now_ms;
        item_next.mask          = gate ? 4'd0 : s_cmd_mask;
        item_next.alt_req       = gate ? 1'b0 : s_alternate_request;
        item_next.accum_temp    = s_accum_temp_decic;
        item_next.motor_speed   = s_motor_speed;
        item_next.coolant_valid = s_coolant_valid;
        item_next.coolant_temp  = s_coolant_temp_decic;
        item_next.pump_demand   = s_pump_demand;
        item_next.sense         = s_relay_sense;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 1'b0;
        end else if (s_ready) begin
            hold_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

>>> hw/rtl/rpcm_queue.sv
// ----------------------------------------------------------------------------
// rpcm_queue: small FIFO between the front and the back
// Lets the input side keep taking beats while the back is stalled, until it is full.
// ----------------------------------------------------------------------------
module rpcm_queue
    import rpcm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       w_valid,
    output logic       w_ready,
    input  rpcm_item_t w_item,
    output logic       r_valid,
    input  logic       r_ready,
    output rpcm_item_t r_item
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);

    rpcm_item_t     mem [QUEUE_DEPTH];
    logic [AW-1:0]  wp_reg, rp_reg;
    logic [AW:0]    cnt_reg;
    logic           wr, rd;

    assign w_ready = (cnt_reg != AW'(0) + (AW+1)'(QUEUE_DEPTH));
    assign r_valid = (cnt_reg != '0);
    assign r_item  = mem[rp_reg];
    assign wr = w_valid && w_ready;
    assign rd = r_valid && r_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + AW'(1);
            if (rd) rp_reg <= rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) mem[wp_reg] <= w_item;
    end

endmodule

>>> hw/rtl/rpcm_back.sv
// ----------------------------------------------------------------------------
// rpcm_back: event execution
// Applies one event per cycle, while the result is free or taken, and registers the result.
// ----------------------------------------------------------------------------
module rpcm_back
    import rpcm_pkg::*;
#(
    parameter int unsigned SETTLE_MS = SETTLE_MS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               q_valid,
    output logic               q_ready,
    input  rpcm_item_t         q_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_drive_mask,
    output logic [3:0]         m_sensed_mask,
    output logic [3:0]         m_commanded_bits,
    output logic [11:0]        m_relay_states,
    output logic               m_fault_raised,
    output logic               m_alternate_active,
    output logic               m_alternate_phase,
    output logic [31:0]        m_ms_since_command
);

    // configuration
    logic [31:0]        ovr_win_reg, lockout_reg, alt_period_reg;
    logic signed [15:0] rad_on_reg, rad_off_reg, acc_on_reg, acc_off_reg, max_rpm_reg;

    // state
    logic [3:0]  commanded_reg, commanded_next;
    logic [3:0]  driven_reg, driven_next;
    logic [3:0]  sensed_reg, sensed_next;
    ch_state_t   chst_reg [CHANNELS];
    ch_state_t   chst_next [CHANNELS];
    logic [31:0] entry_reg [CHANNELS];
    logic [31:0] entry_next [CHANNELS];
    logic [31:0] cmd_time_reg, cmd_time_next;
    logic [3:0]  ovr_bits_reg, ovr_bits_next;
    logic [31:0] ovr_time_reg, ovr_time_next;
    logic        ovr_on_reg, ovr_on_next;
    logic        alt_cmd_reg, alt_cmd_next;
    logic        alt_temp_reg, alt_temp_next;
    logic        alt_act_reg, alt_act_next;
    logic        alt_phase_reg, alt_phase_next;
    logic [31:0] alt_tog_reg, alt_tog_next;
    logic        rad_req_reg, rad_req_next;
    logic        spd_valid_reg, spd_valid_next;
    logic signed [15:0] spd_reg, spd_next;

    logic        out_valid_reg;
    logic        fault_next;
    logic        go;
    logic [3:0]  eff;
    logic        do_recompute, act;
    logic [31:0] now;
    logic [11:0] states_w;

    assign cfg_ready = 1'b1;
    assign q_ready   = !out_valid_reg || m_ready;
    assign go        = q_valid && q_ready;
    assign m_valid   = out_valid_reg;
    assign now       = q_item.now_ms;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovr_win_reg    <= 32'd30000;
            lockout_reg    <= 32'd5000;
            alt_period_reg <= 32'd30000;
            rad_on_reg     <= 16'sd600;
            rad_off_reg    <= 16'sd500;
            acc_on_reg     <= 16'sd450;
            acc_off_reg    <= 16'sd400;
            max_rpm_reg    <= 16'sd3000;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_OVR_WINDOW: ovr_win_reg    <= cfg_data;
                CFG_LOCKOUT:    lockout_reg    <= cfg_data;
                CFG_ALT_PERIOD: alt_period_reg <= cfg_data;
                CFG_RAD_ON:     rad_on_reg     <= cfg_data[15:0];
                CFG_RAD_OFF:    rad_off_reg    <= cfg_data[15:0];
                CFG_ACC_ON:     acc_on_reg     <= cfg_data[15:0];
                CFG_ACC_OFF:    acc_off_reg    <= cfg_data[15:0];
                CFG_MAX_RPM:    max_rpm_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        commanded_next = commanded_reg;
        driven_next    = driven_reg;
        sensed_next    = sensed_reg;
        cmd_time_next  = cmd_time_reg;
        ovr_bits_next  = ovr_bits_reg;
        ovr_time_next  = ovr_time_reg;
        ovr_on_next    = ovr_on_reg;
        alt_cmd_next   = alt_cmd_reg;
        alt_temp_next  = alt_temp_reg;
        alt_act_next   = alt_act_reg;
        alt_phase_next = alt_phase_reg;
        alt_tog_next   = alt_tog_reg;
        rad_req_next   = rad_req_reg;
        spd_valid_next = spd_valid_reg;
        spd_next       = spd_reg;
        for (int i = 0; i < CHANNELS; i++) begin
            chst_next[i]  = chst_reg[i];
            entry_next[i] = entry_reg[i];
        end
        fault_next   = 1'b0;
        do_recompute = q_item.valid_type;
        act          = 1'b0;
        eff          = 4'd0;

        // tick: settle check, sensed update, then phase flip
        if (q_item.ev == EV_TICK) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if ((chst_reg[i] == ST_TON || chst_reg[i] == ST_TOFF) &&
                    (now - entry_reg[i]) >= 32'(SETTLE_MS)) begin
                    if ((chst_reg[i] == ST_TON) == q_item.sense[i]) begin
                        chst_next[i] = (chst_reg[i] == ST_TON) ? ST_ON : ST_OFF;
                    end else begin
                        chst_next[i] = ST_FAULT;
                        fault_next   = 1'b1;
                    end
                end
            end
            sensed_next = q_item.sense;
            if (alt_act_reg && (now - alt_tog_reg) >= alt_period_reg) begin
                alt_phase_next = !alt_phase_reg;
                alt_tog_next   = now;
            end
        end

        if (q_item.ev == EV_VCU || q_item.ev == EV_ALT) alt_cmd_next = q_item.alt_req;
        if (q_item.ev == EV_ACCUM) begin
            if (q_item.accum_temp >= acc_on_reg)       alt_temp_next = 1'b1;
            else if (q_item.accum_temp <= acc_off_reg) alt_temp_next = 1'b0;
        end
        if (q_item.ev == EV_VCU || q_item.ev == EV_ACCUM || q_item.ev == EV_ALT) begin
            act = alt_cmd_next || alt_temp_next;
            if (act && !alt_act_reg) begin
                alt_phase_next = 1'b0;
                alt_tog_next   = now;
            end
            alt_act_next = act;
        end
        if (q_item.ev == EV_VCU) begin
            ovr_bits_next = q_item.mask & 4'b1001;
            ovr_time_next = now;
            ovr_on_next   = 1'b1;
        end
        if (q_item.ev == EV_VCU || q_item.ev == EV_APPLY) commanded_next = q_item.mask;
        if (q_item.ev == EV_VCU || q_item.ev == EV_ALT || q_item.ev == EV_APPLY)
            cmd_time_next = now;
        if (q_item.ev == EV_SPEED) begin
            spd_next       = q_item.motor_speed;
            spd_valid_next = 1'b1;
        end

        if (do_recompute) begin
            eff = commanded_next & 4'b0110;
            if (q_item.coolant_valid) begin
                if (q_item.coolant_temp >= rad_on_reg)       rad_req_next = 1'b1;
                else if (q_item.coolant_temp <= rad_off_reg) rad_req_next = 1'b0;
            end
            if (ovr_on_next && (now - ovr_time_next) >= ovr_win_reg) ovr_on_next = 1'b0;
            if (ovr_on_next) begin
                eff = eff | ovr_bits_next;
            end else begin
                if (q_item.pump_demand) eff[BIT_PUMP] = 1'b1;
                if (rad_req_next && spd_valid_next && spd_next <= max_rpm_reg)
                    eff[BIT_RAD] = 1'b1;
            end
            if (alt_act_next) begin
                eff[BIT_DRS]  = !alt_phase_next;
                eff[BIT_FANS] = alt_phase_next;
            end
            if (eff[BIT_DRS] && eff[BIT_FANS]) begin
                eff[BIT_FANS] = 1'b0;
                fault_next    = 1'b1;
            end
            if (now < lockout_reg) eff = 4'd0;
            for (int i = 0; i < CHANNELS; i++) begin
                if (eff[i] != q_item.sense[i]) begin
                    driven_next[i] = eff[i];
                    chst_next[i]   = eff[i] ? ST_TON : ST_TOFF;
                    entry_next[i]  = now;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) states_w[3*i +: 3] = chst_next[i];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            commanded_reg <= '0; driven_reg <= '0; sensed_reg <= '0;
            cmd_time_reg  <= '0; ovr_bits_reg <= '0; ovr_time_reg <= '0;
            ovr_on_reg    <= 1'b0; alt_cmd_reg <= 1'b0; alt_temp_reg <= 1'b0;
            alt_act_reg   <= 1'b0; alt_phase_reg <= 1'b0; alt_tog_reg <= '0;
            rad_req_reg   <= 1'b0; spd_valid_reg <= 1'b0; spd_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                chst_reg[i]  <= ST_OFF;
                entry_reg[i] <= '0;
            end
        end else begin
            if (q_ready) out_valid_reg <= q_valid;
            if (go) begin
                commanded_reg <= commanded_next; driven_reg <= driven_next;
                sensed_reg    <= sensed_next;    cmd_time_reg <= cmd_time_next;
                ovr_bits_reg  <= ovr_bits_next;  ovr_time_reg <= ovr_time_next;
                ovr_on_reg    <= ovr_on_next;    alt_cmd_reg  <= alt_cmd_next;
                alt_temp_reg  <= alt_temp_next;  alt_act_reg  <= alt_act_next;
                alt_phase_reg <= alt_phase_next; alt_tog_reg  <= alt_tog_next;
                rad_req_reg   <= rad_req_next;   spd_valid_reg <= spd_valid_next;
                spd_reg       <= spd_next;
                for (int i = 0; i < CHANNELS; i++) begin
                    chst_reg[i]  <= chst_next[i];
                    entry_reg[i] <= entry_next[i];
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (go) begin
            m_drive_mask       <= driven_next;
            m_sensed_mask      <= sensed_next;
            m_commanded_bits   <= commanded_next;
            m_relay_states     <= states_w;
            m_fault_raised     <= fault_next;
            m_alternate_active <= alt_act_next;
            m_alternate_phase  <= alt_phase_next;
            m_ms_since_command <= now - cmd_time_next;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive_mask))
        else $error("result changed while stalled");
    a_no_take_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !q_ready)
        else $error("back took a beat while output stalled");
    a_states_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_relay_states[2:0] <= ST_FAULT) && (m_relay_states[5:3] <= ST_FAULT)
                    && (m_relay_states[8:6] <= ST_FAULT)
                    && (m_relay_states[11:9] <= ST_FAULT))
        else $error("illegal channel state code");

endmodule
